>>> rtl/core/pursuit_steering_controller_assert.svh
// Assertion macros used by the checker of the pursuit steering controller.
`ifndef PURSUIT_STEERING_CONTROLLER_ASSERT_SVH
`define PURSUIT_STEERING_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PSC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pursuit steering controller: assertion failed");

// Next-cycle implication, disabled while in reset.
`define PSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pursuit steering controller: assertion failed");

`endif

>>> rtl/core/psc_pkg.sv
// Package: widths, constants, types and the arctangent table of the pursuit controller.
`default_nettype none
package psc_pkg;

	// CORDIC micro-rotations per tick (8 to 24)
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int STEP_W       = $clog2(TABLE_LEN);

	// field widths
	localparam int POS_W   = 16;
	localparam int ANG_W   = 16;
	localparam int REG_W   = 16;
	localparam int SPEED_W = 16;
	localparam int TURN_W  = 20;
	localparam int MODE_W  = 2;
	localparam int ADDR_W  = 3;

	// internal widths
	localparam int DIFF_W = POS_W + 1;
	localparam int HEAD_W = ANG_W + 1;
	localparam int XY_W   = 28;
	localparam int Z_W    = 34;
	localparam int ATAN_W = 30;
	localparam int DIST_W = 18;
	localparam int ERR_W  = 18;
	localparam int MA_W   = 29;
	localparam int MB_W   = 19;
	localparam int PROD_W = MA_W + MB_W;
	localparam int PRE_SHIFT_BITS = 8;
	localparam int DIST_SHIFT = 24;
	localparam int BEAR_SHIFT = 17;
	localparam int GAIN_SHIFT = 12;

	// constants
	localparam logic signed [Z_W-1:0]    PI_Z       = 34'sd3373259426;
	localparam logic signed [Z_W-1:0]    BEAR_RND   = 34'sd65536;
	localparam logic [REG_W-1:0]         INV_K      = 16'd39797;
	localparam logic signed [PROD_W-1:0] DIST_RND   = 48'sd8388608;
	localparam logic signed [PROD_W-1:0] GAIN_RND   = 48'sd2048;
	localparam logic signed [ERR_W-1:0]  PI_Q13     = 18'sd25736;
	localparam logic signed [ERR_W-1:0]  TWO_PI_Q13 = 18'sd51472;
	localparam logic [TURN_W-1:0]        TURN_MAX   = 20'h7FFFF;
	localparam logic [TURN_W-1:0]        TURN_MIN   = 20'h80000;

	// input item kinds
	localparam logic [MODE_W-1:0] MODE_TARGET = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OWN    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	// configuration register indices
	localparam logic [ADDR_W-1:0] REG_STOP_DISTANCE = 3'd0;
	localparam logic [ADDR_W-1:0] REG_SPEED_GAIN    = 3'd1;
	localparam logic [ADDR_W-1:0] REG_MAX_SPEED     = 3'd2;
	localparam logic [ADDR_W-1:0] REG_TURN_GAIN     = 3'd3;

	// datapath operations issued by the sequencer
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOAD,
		OP_ROT,
		OP_MUL_DIST,
		OP_CHECK,
		OP_WRAP,
		OP_MUL_SPEED,
		OP_MUL_TURN
	} psc_op_t;

	typedef struct packed {
		psc_op_t           op;
		logic [STEP_W-1:0] step;
		logic              load_out;
	} psc_ctrl_t;

	typedef struct packed {
		logic near;
		logic err_ok;
	} psc_status_t;

	typedef struct packed {
		logic [REG_W-1:0] stop_distance;
		logic [REG_W-1:0] speed_gain;
		logic [REG_W-1:0] max_speed;
		logic [REG_W-1:0] turn_gain;
	} psc_cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]         target_x;
		logic [POS_W-1:0]         target_y;
		logic [POS_W-1:0]         own_x;
		logic [POS_W-1:0]         own_y;
		logic signed [HEAD_W-1:0] own_heading;
		logic                     target_seen;
		logic                     own_seen;
	} psc_pose_t;

	// atan(2^-i) scaled by 2^30
	function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		unique case (idx)
			5'd0:    v = 30'd843314856;
			5'd1:    v = 30'd497837829;
			5'd2:    v = 30'd263043836;
			5'd3:    v = 30'd133525158;
			5'd4:    v = 30'd67021686;
			5'd5:    v = 30'd33543515;
			5'd6:    v = 30'd16775850;
			5'd7:    v = 30'd8388437;
			5'd8:    v = 30'd4194282;
			5'd9:    v = 30'd2097149;
			5'd10:   v = 30'd1048575;
			5'd11:   v = 30'd524287;
			5'd12:   v = 30'd262143;
			5'd13:   v = 30'd131071;
			5'd14:   v = 30'd65535;
			5'd15:   v = 30'd32767;
			5'd16:   v = 30'd16383;
			5'd17:   v = 30'd8191;
			5'd18:   v = 30'd4095;
			5'd19:   v = 30'd2047;
			5'd20:   v = 30'd1023;
			5'd21:   v = 30'd511;
			5'd22:   v = 30'd255;
			5'd23:   v = 30'd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/psc_store.sv
// Configuration registers and the latest target and own poses with their seen flags.
`default_nettype none
module psc_store (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [psc_pkg::ADDR_W-1:0]     cfg_addr,
	input  wire  [psc_pkg::REG_W-1:0]      cfg_data,
	input  wire                            pose_we,
	input  wire  [psc_pkg::MODE_W-1:0]     mode,
	input  wire  [psc_pkg::POS_W-1:0]      pos_x,
	input  wire  [psc_pkg::POS_W-1:0]      pos_y,
	input  wire  [psc_pkg::ANG_W-1:0]      heading,
	output psc_pkg::psc_cfg_t              cfg,
	output psc_pkg::psc_pose_t             pose,
	output logic                           both_seen
);
	import psc_pkg::*;

	psc_cfg_t  cfg_q;
	psc_pose_t pose_q;

	// register writes; indices beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_distance <= 16'd1024;
			cfg_q.speed_gain    <= 16'd8192;
			cfg_q.max_speed     <= 16'd4096;
			cfg_q.turn_gain     <= 16'd16384;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_STOP_DISTANCE: cfg_q.stop_distance <= cfg_data;
				REG_SPEED_GAIN:    cfg_q.speed_gain    <= cfg_data;
				REG_MAX_SPEED:     cfg_q.max_speed     <= cfg_data;
				REG_TURN_GAIN:     cfg_q.turn_gain     <= cfg_data;
				default: ;
			endcase
		end
	end

	// pose updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q <= '0;
		end else if (pose_we) begin
			if (mode == MODE_TARGET) begin
				pose_q.target_x    <= pos_x;
				pose_q.target_y    <= pos_y;
				pose_q.target_seen <= 1'b1;
			end else if (mode == MODE_OWN) begin
				pose_q.own_x       <= pos_x;
				pose_q.own_y       <= pos_y;
				pose_q.own_heading <= {heading[ANG_W-1], heading};
				pose_q.own_seen    <= 1'b1;
			end
		end
	end

	assign cfg       = cfg_q;
	assign pose      = pose_q;
	assign both_seen = pose_q.target_seen & pose_q.own_seen;

endmodule
`default_nettype wire

>>> rtl/core/psc_datapath.sv
// Shared arithmetic unit: CORDIC shift-add step, one multiplier, heading wrap, result register.
`default_nettype none
module psc_datapath (
	input  wire                               clk,
	input  psc_pkg::psc_cfg_t                 cfg,
	input  psc_pkg::psc_pose_t                pose,
	input  psc_pkg::psc_ctrl_t                ctrl,
	output psc_pkg::psc_status_t              status,
	output logic [psc_pkg::SPEED_W-1:0]       forward_speed,
	output logic [psc_pkg::TURN_W-1:0]        turn_rate
);
	import psc_pkg::*;

	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [Z_W-1:0]    z_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [DIST_W-1:0]        dist_q;
	logic signed [ERR_W-1:0]  err_q;
	logic                     near_q;
	logic [SPEED_W-1:0]       speed_q;
	logic [SPEED_W-1:0]       fwd_q;
	logic [TURN_W-1:0]        turn_q;

	logic signed [DIFF_W-1:0] dx, dy;
	logic signed [XY_W-1:0]   dx_ext, dy_ext;
	logic signed [XY_W-1:0]   xs, ys;
	logic signed [Z_W-1:0]    atan_z;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_w;
	logic [PROD_W-1:0]        dist_sum;
	logic [DIST_W-1:0]        dist_w;
	logic signed [Z_W-1:0]    bear_sum;
	logic signed [ERR_W-1:0]  err_w;
	logic [PROD_W-1:0]        sp_sum;
	logic [PROD_W-GAIN_SHIFT-1:0] sp_w;
	logic [SPEED_W-1:0]       sp_clamp;
	logic [PROD_W-1:0]        tr_sum;
	logic [PROD_W-GAIN_SHIFT-1:0] tr_w;
	logic [TURN_W-1:0]        tr_sat;

	// offset from own position to target, scaled for the CORDIC
	assign dx     = $signed({1'b0, pose.target_x}) - $signed({1'b0, pose.own_x});
	assign dy     = $signed({1'b0, pose.target_y}) - $signed({1'b0, pose.own_y});
	assign dx_ext = XY_W'(dx) <<< PRE_SHIFT_BITS;
	assign dy_ext = XY_W'(dy) <<< PRE_SHIFT_BITS;

	// micro-rotation operands
	assign xs     = x_q >>> ctrl.step;
	assign ys     = y_q >>> ctrl.step;
	assign atan_z = $signed({{(Z_W-ATAN_W){1'b0}}, atan_lut(ctrl.step)});

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.op)
			OP_MUL_DIST: begin
				mul_a = {x_q[XY_W-1], x_q};
				mul_b = $signed({{(MB_W-REG_W){1'b0}}, INV_K});
			end
			OP_MUL_SPEED: begin
				mul_a = $signed({{(MA_W-REG_W){1'b0}}, cfg.speed_gain});
				mul_b = $signed({{(MB_W-DIST_W){1'b0}}, dist_q});
			end
			OP_MUL_TURN: begin
				mul_a = $signed({{(MA_W-REG_W){1'b0}}, cfg.turn_gain});
				mul_b = {err_q[ERR_W-1], err_q};
			end
			default: ;
		endcase
	end

	// the one multiplier
	assign prod_w = mul_a * mul_b;

	// distance and bearing from the rotated vector
	assign dist_sum = prod_q + DIST_RND;
	assign dist_w   = dist_sum[DIST_SHIFT +: DIST_W];
	assign bear_sum = z_q + BEAR_RND;
	assign err_w    = ERR_W'($signed(bear_sum[Z_W-1:BEAR_SHIFT])) - ERR_W'(pose.own_heading);

	// forward speed: round, then clamp
	assign sp_sum   = prod_q + GAIN_RND;
	assign sp_w     = sp_sum[PROD_W-1:GAIN_SHIFT];
	assign sp_clamp = (sp_w > {{(PROD_W-GAIN_SHIFT-REG_W){1'b0}}, cfg.max_speed}) ?
		cfg.max_speed : sp_w[SPEED_W-1:0];

	// turn rate: round, then saturate
	assign tr_sum = prod_q + GAIN_RND;
	assign tr_w   = tr_sum[PROD_W-1:GAIN_SHIFT];
	assign tr_sat = (tr_w[PROD_W-GAIN_SHIFT-1:TURN_W-1] ==
		{(PROD_W-GAIN_SHIFT-TURN_W+1){tr_w[TURN_W-1]}}) ? tr_w[TURN_W-1:0] :
		(tr_w[PROD_W-GAIN_SHIFT-1] ? TURN_MIN : TURN_MAX);

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.op) inside
			OP_LOAD: begin
				if (dx < 0) begin
					x_q <= -dx_ext;
					y_q <= -dy_ext;
					z_q <= (dy >= 0) ? PI_Z : -PI_Z;
				end else begin
					x_q <= dx_ext;
					y_q <= dy_ext;
					z_q <= '0;
				end
			end
			OP_ROT: begin
				if (y_q < 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_z;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_z;
				end
			end
			OP_MUL_DIST, OP_MUL_SPEED: prod_q <= prod_w;
			OP_CHECK: begin
				dist_q <= dist_w;
				err_q  <= err_w;
				near_q <= dist_w <= {{(DIST_W-REG_W){1'b0}}, cfg.stop_distance};
			end
			OP_WRAP: begin
				if (err_q > PI_Q13) err_q <= err_q - TWO_PI_Q13;
				else                err_q <= err_q + TWO_PI_Q13;
			end
			OP_MUL_TURN: begin
				speed_q <= sp_clamp;
				prod_q  <= prod_w;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			fwd_q  <= near_q ? '0 : speed_q;
			turn_q <= near_q ? '0 : tr_sat;
		end
	end

	assign status.near   = near_q;
	assign status.err_ok = (err_q <= PI_Q13) && (err_q >= -PI_Q13);
	assign forward_speed = fwd_q;
	assign turn_rate     = turn_q;

endmodule
`default_nettype wire

>>> rtl/core/psc_seq.sv
// Sequencer: steps the shared datapath through one control tick and owns the handshakes.
`default_nettype none
module psc_seq (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	input  wire  [psc_pkg::MODE_W-1:0]  mode,
	input  wire                         both_seen,
	input  psc_pkg::psc_status_t        status,
	input  wire                         out_ready,
	output logic                        in_ready,
	output logic                        out_valid,
	output psc_pkg::psc_ctrl_t          ctrl
);
	import psc_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_LOAD  = 9'b000000010,
		S_ROT   = 9'b000000100,
		S_DIST  = 9'b000001000,
		S_CHECK = 9'b000010000,
		S_WRAP  = 9'b000100000,
		S_SPEED = 9'b001000000,
		S_TURN  = 9'b010000000,
		S_DONE  = 9'b100000000
	} psc_state_t;

	psc_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	// next state and operation
	always_comb begin
		state_d       = state_q;
		ctrl.op       = OP_IDLE;
		ctrl.step     = step_q;
		ctrl.load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && (mode == MODE_TICK) && both_seen) state_d = S_LOAD;
			end
			S_LOAD: begin
				ctrl.op = OP_LOAD;
				state_d = S_ROT;
			end
			S_ROT: begin
				ctrl.op = OP_ROT;
				if (step_q == LAST_STEP) state_d = S_DIST;
			end
			S_DIST: begin
				ctrl.op = OP_MUL_DIST;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				ctrl.op = OP_CHECK;
				state_d = S_WRAP;
			end
			S_WRAP: begin
				if (status.near)        state_d = S_DONE;
				else if (status.err_ok) state_d = S_SPEED;
				else                    ctrl.op = OP_WRAP;
			end
			S_SPEED: begin
				ctrl.op = OP_MUL_SPEED;
				state_d = S_TURN;
			end
			S_TURN: begin
				ctrl.op = OP_MUL_TURN;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctrl.load_out = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state, rotation counter and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LOAD)     step_q <= '0;
			else if (state_q == S_ROT) step_q <= step_q + 1'b1;
			if (ctrl.load_out)  out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/core/pursuit_steering_controller.sv
// Pursuit steering controller (top level): turns pose updates and control ticks into commands.
// Target and own pose updates are taken whenever the block is idle and produce no result.
// A control tick, once both poses have been seen, runs from its transfer to its result
// through the load, the CORDIC rotations, the distance product and the check, then, outside
// the stop distance, at most one heading wrap step and the speed and turn products; it waits
// in its last state while an earlier result is still pending, and s_tready is low throughout.
// The CORDIC vectoring does one micro-rotation per cycle through a single shift-add unit, and
// a shared multiplier is used for distance, speed and turn rate. The result waits in an output
// register, so the next item is taken while it is still pending. Both commands are zero
// whenever the distance is not above stop_distance; register writes are taken at any time on
// the cfg channel.
`default_nettype none
module pursuit_steering_controller (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32]
	input  wire  [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // forward_speed[15:0], turn_rate[35:16], zero[39:36]
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_addr,
	input  wire  [15:0] cfg_data
);
	import psc_pkg::*;

	psc_cfg_t           cfg;
	psc_pose_t          pose;
	psc_ctrl_t          ctrl;
	psc_status_t        status;
	logic               both_seen;
	logic               in_xfer;
	logic [SPEED_W-1:0] forward_speed;
	logic [TURN_W-1:0]  turn_rate;

	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid & s_tready;

	psc_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.pose_we   (in_xfer),
		.mode      (s_tuser),
		.pos_x     (s_tdata[15:0]),
		.pos_y     (s_tdata[31:16]),
		.heading   (s_tdata[47:32]),
		.cfg       (cfg),
		.pose      (pose),
		.both_seen (both_seen)
	);

	psc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.mode      (s_tuser),
		.both_seen (both_seen),
		.status    (status),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.ctrl      (ctrl)
	);

	psc_datapath u_datapath (
		.clk           (clk),
		.cfg           (cfg),
		.pose          (pose),
		.ctrl          (ctrl),
		.status        (status),
		.forward_speed (forward_speed),
		.turn_rate     (turn_rate)
	);

	assign m_tdata = {4'b0000, turn_rate, forward_speed};

endmodule
`default_nettype wire

>>> rtl/core/psc_checker.sv
// Port-level checker for the pursuit steering controller, bound to the top level.
`default_nettype none
`include "pursuit_steering_controller_assert.svh"
module psc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [1:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata
);
	import psc_pkg::*;

	// a pending result holds until it is taken
	`PSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// the block only goes busy after taking a control tick
	`PSC_ASSERT_SAME(a_busy_on_tick, $fell(s_tready), $past(s_tvalid) && ($past(s_tuser) == MODE_TICK))

	// a result only appears at the end of a busy period
	`PSC_ASSERT_SAME(a_result_from_busy, $rose(m_tvalid), $past(!s_tready))

	// pose updates and ignored kinds never produce a result
	`PSC_ASSERT_NEXT(a_pose_no_result, s_tvalid && s_tready && (s_tuser != MODE_TICK) && !m_tvalid, !m_tvalid)

endmodule

bind pursuit_steering_controller psc_checker u_psc_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the pursuit steering controller: pose updates, ticks, register writes.
module tb_top;

	// streaming item kind that the block drops without effect
	localparam logic [1:0] MODE_IGNORED  = 2'd3;
	// register indices past the end of the register list
	localparam logic [2:0] REG_UNUSED_LO = 3'd4;
	localparam logic [2:0] REG_UNUSED_HI = 3'd7;

	localparam logic [15:0] HEAD_PI      = 16'd25736;
	localparam logic [15:0] HEAD_NEG_PI  = 16'hFFFF - 16'd25735;
	localparam logic [15:0] HEAD_MAX     = 16'h7FFF;
	localparam logic [15:0] HEAD_MIN     = 16'h8000;
	localparam logic [15:0] POS_MAX      = 16'hFFFF;

	// bearing and wrap arithmetic
	localparam longint ANG_PI_Z30     = 64'sd3373259426;
	localparam longint ANG_PI_Q13     = 25736;
	localparam longint ANG_2PI_Q13    = 51472;
	localparam longint INV_GAIN_Q16   = 39797;
	localparam longint TURN_CEIL      = 524287;
	localparam longint TURN_FLOOR     = -524288;
	localparam int     ATAN_ENTRIES   = 24;
	localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};

	// wait for a tick still in flight after the queue is empty; leave some margin
	localparam int DRAIN_CYCLES = psc_pkg::CORDIC_STEPS + 16;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		logic [15:0] speed;
		logic [19:0] turn;
	} steer_cmd_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;   // pos_x[15:0], pos_y[31:16], heading[47:32]
	logic [1:0]  s_tuser   = '0;   // mode[1:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // forward_speed[15:0], turn_rate[35:16], zero[39:36]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_addr  = '0;
	logic [15:0] cfg_data  = '0;

	// predictor state
	logic [15:0]        cfg_stop       = 16'd1024;
	logic [15:0]        cfg_speed_gain = 16'd8192;
	logic [15:0]        cfg_max_speed  = 16'd4096;
	logic [15:0]        cfg_turn_gain  = 16'd16384;
	logic [15:0]        tgt_x = '0, tgt_y = '0, own_x = '0, own_y = '0;
	logic signed [16:0] own_hdg  = '0;
	logic               tgt_seen = 1'b0, own_seen = 1'b0;

	steer_cmd_t cmd_expected[$];
	steer_cmd_t got_cmd, want_cmd;

	bit gaps_on       = 1'b1;
	int rx_wait       = 0;
	int items_sent    = 0;
	int cmds_checked  = 0;
	int reg_writes    = 0;
	int fail_count    = 0;
	int cycles        = 0;

	pursuit_steering_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d commands outstanding", cycles,
				cmd_expected.size());
			$display("pursuit_steering_controller verification failed");
			$finish;
		end
	end

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("MISMATCH @%0d: %s", cycles, msg);
	endfunction

	// Update pose state; a tick with both poses known queues the expected command.
	task automatic track_item(input logic [1:0] mode, input logic [15:0] px, py, hd);
		longint dx, dy, x, y, z, xs, ys, range_q11, bearing, err, speed, turn;
		steer_cmd_t cmd;
		case (mode)
			psc_pkg::MODE_TARGET: begin
				tgt_x    = px;
				tgt_y    = py;
				tgt_seen = 1'b1;
			end
			psc_pkg::MODE_OWN: begin
				own_x    = px;
				own_y    = py;
				own_hdg  = $signed(hd);
				own_seen = 1'b1;
			end
			psc_pkg::MODE_TICK: begin
				if (tgt_seen && own_seen) begin
					dx = longint'(tgt_x) - longint'(own_x);
					dy = longint'(tgt_y) - longint'(own_y);
					x  = dx * 256;
					y  = dy * 256;
					z  = 0;
					// left half-plane: turn the vector round by pi first
					if (dx < 0) begin
						x = -x;
						y = -y;
						z = (dy >= 0) ? ANG_PI_Z30 : -ANG_PI_Z30;
					end
					for (int k = 0; k < psc_pkg::CORDIC_STEPS && k < ATAN_ENTRIES; k++) begin
						xs = x >>> k;
						ys = y >>> k;
						if (y < 0) begin
							x = x - ys;
							y = y + xs;
							z = z - ATAN_Q30[k];
						end else begin
							x = x + ys;
							y = y - xs;
							z = z + ATAN_Q30[k];
						end
					end
					range_q11 = (x * INV_GAIN_Q16 + 64'sd8388608) >>> 24;
					bearing   = (z + 64'sd65536) >>> 17;
					if (range_q11 <= longint'(cfg_stop)) begin
						cmd = '0;
					end else begin
						err = bearing - longint'(own_hdg);
						while (err > ANG_PI_Q13)
							err -= ANG_2PI_Q13;
						while (err < -ANG_PI_Q13)
							err += ANG_2PI_Q13;
						speed = (longint'(cfg_speed_gain) * range_q11 + 2048) >>> 12;
						if (speed > longint'(cfg_max_speed))
							speed = longint'(cfg_max_speed);
						turn = (longint'(cfg_turn_gain) * err + 2048) >>> 12;
						if (turn > TURN_CEIL)
							turn = TURN_CEIL;
						if (turn < TURN_FLOOR)
							turn = TURN_FLOOR;
						cmd.speed = speed[15:0];
						cmd.turn  = turn[19:0];
					end
					cmd_expected.push_back(cmd);
				end
			end
			default: ;
		endcase
	endtask

	// One input transfer, with a random gap in front of it.
	task automatic send_item(input logic [1:0] mode, input logic [15:0] px, py, hd);
		int gap;
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {hd, py, px};
		do @(posedge clk); while (!s_tready);
		track_item(mode, px, py, hd);
		items_sent++;
	endtask

	// One register transfer; only called while the block is idle.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			psc_pkg::REG_STOP_DISTANCE: cfg_stop       = val;
			psc_pkg::REG_SPEED_GAIN:    cfg_speed_gain = val;
			psc_pkg::REG_MAX_SPEED:     cfg_max_speed  = val;
			psc_pkg::REG_TURN_GAIN:     cfg_turn_gain  = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending, let every queued command arrive, then allow for a tick still in flight.
	task automatic drain_block;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cmd_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] stop, sgain, smax, tgain);
		drain_block();
		write_reg(psc_pkg::REG_STOP_DISTANCE, stop);
		write_reg(psc_pkg::REG_SPEED_GAIN, sgain);
		write_reg(psc_pkg::REG_MAX_SPEED, smax);
		write_reg(psc_pkg::REG_TURN_GAIN, tgain);
	endtask

	// Mostly pose updates followed by ticks, with some positions close to the other pose.
	task automatic random_pursuit_items(input int count);
		logic [1:0]  mode;
		logic [15:0] px, py, hd, near_x, near_y;
		int          pick;
		for (int n = 0; n < count; n++) begin
			if (n % 25 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			mode = (pick < 35) ? psc_pkg::MODE_TARGET :
				(pick < 65) ? psc_pkg::MODE_OWN :
				(pick < 96) ? psc_pkg::MODE_TICK : MODE_IGNORED;
			near_x = (mode == psc_pkg::MODE_TARGET) ? own_x : tgt_x;
			near_y = (mode == psc_pkg::MODE_TARGET) ? own_y : tgt_y;
			case ($urandom_range(0, 9))
				6, 7: begin
					px = near_x + 16'($urandom_range(0, 4095)) - 16'd2048;
					py = near_y + 16'($urandom_range(0, 4095)) - 16'd2048;
				end
				8: begin
					px = $urandom_range(0, 1) ? POS_MAX : '0;
					py = $urandom_range(0, 1) ? POS_MAX : '0;
				end
				9: begin
					px = near_x;
					py = near_y;
				end
				default: begin
					px = 16'($urandom_range(0, 65535));
					py = 16'($urandom_range(0, 65535));
				end
			endcase
			if ($urandom_range(0, 9) == 0)
				hd = 16'($urandom_range(0, 65535));
			else
				hd = 16'($urandom_range(0, 51472) - 25736);
			send_item(mode, px, py, hd);
		end
	endtask

	// Ticks give nothing until both poses are known.
	task automatic test_tick_gating;
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
		send_item(MODE_IGNORED, POS_MAX, POS_MAX, 16'hFFFF);
		send_item(psc_pkg::MODE_TARGET, POS_MAX, POS_MAX, '0);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
		send_item(psc_pkg::MODE_OWN, '0, '0, HEAD_PI);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
	endtask

	// Corner positions and both left-half-plane branches.
	task automatic test_geometry_extremes;
		send_item(psc_pkg::MODE_OWN, POS_MAX, POS_MAX, HEAD_NEG_PI);
		send_item(psc_pkg::MODE_TARGET, '0, '0, '0);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
		send_item(psc_pkg::MODE_TARGET, '0, POS_MAX, '0);
		send_item(psc_pkg::MODE_OWN, POS_MAX, '0, '0);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
		send_item(psc_pkg::MODE_OWN, 16'd1000, 16'd2000, '0);
		send_item(psc_pkg::MODE_TARGET, 16'd60000, 16'd2000, '0);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
	endtask

	// Zero offset and a target inside the stop zone.
	task automatic test_stop_zone;
		send_item(psc_pkg::MODE_OWN, 16'd40000, 16'd30000, 16'h4000);
		send_item(psc_pkg::MODE_TARGET, 16'd40000, 16'd30000, '0);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
		send_item(psc_pkg::MODE_TARGET, 16'd40600, 16'd30000, '0);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
	endtask

	// Headings beyond +/-pi still go through the wrap.
	task automatic test_heading_range;
		send_item(psc_pkg::MODE_OWN, 16'd20000, 16'd20000, HEAD_MAX);
		send_item(psc_pkg::MODE_TARGET, 16'd50000, 16'd10000, '0);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
		send_item(psc_pkg::MODE_OWN, 16'd20000, 16'd20000, HEAD_MIN);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
	endtask

	// Writes to unused indices and mode three leave everything as it was.
	task automatic test_ignored_inputs;
		drain_block();
		write_reg(REG_UNUSED_LO, '0);
		write_reg(REG_UNUSED_HI, 16'hFFFF);
		send_item(MODE_IGNORED, '0, '0, '0);
		send_item(psc_pkg::MODE_TICK, '0, '0, '0);
	endtask

	// Every register at both ends of its range.
	task automatic test_register_extremes;
		apply_settings('0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_pursuit_items(60);
		apply_settings(16'hFFFF, '0, '0, '0);
		random_pursuit_items(60);
		apply_settings('0, '0, 16'hFFFF, 16'hFFFF);
		random_pursuit_items(40);
	endtask

	// Bulk random traffic over a spread of register settings.
	task automatic test_random_pursuit;
		logic [15:0] stop;
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 0) begin
				apply_settings(16'd1024, 16'd8192, 16'd4096, 16'd16384);
			end else begin
				stop = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
					16'($urandom_range(0, 4095));
				apply_settings(stop, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			end
			random_pursuit_items(105);
		end
	endtask

	// Receiver stall, random and possibly zero, before each command while gaps are on.
	always @(negedge clk) begin
		m_tready <= (rx_wait == 0);
		if (rx_wait > 0)
			rx_wait--;
	end

	// Command transfers: compare against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			rx_wait = gaps_on ? $urandom_range(0, 7) : 0;
			got_cmd.speed = m_tdata[15:0];
			got_cmd.turn  = m_tdata[35:16];
			cmds_checked++;
			if (cmd_expected.size() == 0) begin
				note_failure($sformatf("unexpected command speed=%0d turn=%0d",
					got_cmd.speed, $signed(got_cmd.turn)));
			end else begin
				want_cmd = cmd_expected.pop_front();
				if (got_cmd.speed !== want_cmd.speed)
					note_failure($sformatf("forward_speed expected %0d got %0d",
						want_cmd.speed, got_cmd.speed));
				if (got_cmd.turn !== want_cmd.turn)
					note_failure($sformatf("turn_rate expected %0d got %0d",
						$signed(want_cmd.turn), $signed(got_cmd.turn)));
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_tick_gating();
		test_geometry_extremes();
		test_stop_zone();
		test_heading_range();
		test_ignored_inputs();
		test_register_extremes();
		test_random_pursuit();
		drain_block();
		$display("Covered %0d input items, %0d commands checked, %0d register writes.",
			items_sent, cmds_checked, reg_writes);
		$display("Mismatches counted: %0d, cycles used: %0d.", fail_count, cycles);
		if (fail_count == 0)
			$display("pursuit_steering_controller verification clean");
		else
			$display("pursuit_steering_controller verification failed");
		$finish;
	end

endmodule
